// File: rtl/core/assert_macros.svh
// Assertion macros for the plotter RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TPP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tpp assertion failed");

// Implication checked in the same cycle.
`define TPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpp assertion failed");

`endif

// File: rtl/core/tpp_pkg.sv
// Package for the turtle plotter: command codes, headings, register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

    typedef enum logic [2:0] {
        REQ_PEN_UP   = 3'd0,
        REQ_PEN_DOWN = 3'd1,
        REQ_RIGHT    = 3'd2,
        REQ_LEFT     = 3'd3,
        REQ_MOVE     = 3'd4,
        REQ_PRINT    = 3'd5,
        REQ_END      = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        HEAD_EAST  = 2'd0,
        HEAD_SOUTH = 2'd1,
        HEAD_WEST  = 2'd2,
        HEAD_NORTH = 2'd3
    } t_head;

    localparam int  ADDR_W      = 3;
    localparam logic REG_START_X = 1'b0;
    localparam logic REG_START_Y = 1'b1;
    localparam int  START_RESET = 15;

endpackage

`default_nettype wire

// File: rtl/core/turtle_pen_plotter_grid_unit.sv
// Turtle plotter top level: command decode, grid memory, print output queue.
// Depends on tpp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// The grid (GRID rows of GRID bits) sits in a synchronous memory with one read and
// one write port and per-row valid flags, so it reads as cleared right after reset
// without a sweep.
// A move with the pen down walks the touched rows through read-modify-write,
// one row per cycle: up to min(distance, GRID - x) rows east, min(distance,
// x + 1) rows west (x the current x position) and one row for north/south.
// Print reads one row per cycle into a two-word output queue while the output
// side keeps up; a stalled output holds it back. A new command is taken once
// the previous one has issued its last memory read, while printed words may
// still wait in the queue.
module turtle_pen_plotter_grid_unit #(
    parameter int GRID = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [2:0]                i_req_type,
    input  wire logic [4:0]                i_distance,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [4:0]                     o_row_index,
    output logic [31:0]                    o_row_bits,
    output logic                           o_last_row,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tpp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tpp_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = (GRID > 1) ? $clog2(GRID) : 1;
    localparam int LW = CW + 1;
    localparam int XW = ((CW > 5) ? CW : 5) + 2;
    localparam int RST_POS = (GRID - 1 < START_RESET) ? GRID - 1 : START_RESET;

    typedef enum logic [1:0] {S_IDLE, S_ROWS, S_PRINT} t_state;

    t_state            r_state;
    logic [CW-1:0]     r_pos_x, r_pos_y;
    logic [4:0]        r_start_x, r_start_y;
    t_head             r_head;
    logic              r_pen, r_halt;
    logic [CW-1:0]     r_row;
    logic [LW-1:0]     r_left;
    logic              r_dir;
    logic [GRID-1:0]   r_mask;

    logic [GRID-1:0]   r_mem [GRID];
    logic [GRID-1:0]   r_vld;
    logic [GRID-1:0]   r_mem_q;
    logic              r_vld_q;
    logic              r_wr_vld;
    logic [CW-1:0]     r_wr_addr;
    logic [GRID-1:0]   r_wr_mask;
    logic              r_pr_vld;
    logic [CW-1:0]     r_pr_idx;
    logic              r_pr_last;

    logic [4:0]        r_fq_idx [2];
    logic [31:0]       r_fq_bits [2];
    logic              r_fq_last [2];
    logic              r_fq_wp, r_fq_rp;
    logic [1:0]        r_fq_cnt;

    logic              in_acc, cfg_wr, pop, credit_ok, rd_en;
    logic [CW-1:0]     rd_addr;
    logic [GRID-1:0]   row_data, wr_data;
    logic [2:0]        fq_used;
    logic [XW-1:0]     dx, px, py, sum_x, sum_y, cnt_e, cnt_w, hi_s, hi_n, lo_n;
    logic [CW-1:0]     newx_e, newx_w, newy_s, newy_n;
    logic [GRID-1:0]   mask_s, mask_n, mask_col;

    function automatic logic [GRID-1:0] low_mask(input logic [XW-1:0] n);
        logic [GRID-1:0] m;
        for (int j = 0; j < GRID; j++) begin
            m[j] = (XW'(j) < n);
        end
        return m;
    endfunction

    function automatic logic [CW-1:0] clamp_start(input logic [4:0] v);
        return (XW'(v) > XW'(GRID - 1)) ? CW'(GRID - 1) : CW'(v);
    endfunction

    assign in_acc     = i_in_valid & o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign cfg_wr     = psel & penable & pwrite & pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_START_Y) ? {27'd0, r_start_y} : {27'd0, r_start_x};

    assign o_out_valid = (r_fq_cnt != 2'd0);
    assign o_row_index = r_fq_idx[r_fq_rp];
    assign o_row_bits  = r_fq_bits[r_fq_rp];
    assign o_last_row  = r_fq_last[r_fq_rp];
    assign pop         = o_out_valid & i_out_ready;
    assign fq_used     = 3'(r_fq_cnt) + 3'(r_pr_vld) - 3'(pop);
    assign credit_ok   = (fq_used < 3'd2);

    assign rd_en   = (r_state == S_ROWS) || ((r_state == S_PRINT) && credit_ok);
    assign rd_addr = r_row;

    assign row_data = r_vld_q ? r_mem_q : '0;
    assign wr_data  = row_data | r_wr_mask;

    // move geometry
    assign dx     = XW'(i_distance);
    assign px     = XW'(r_pos_x);
    assign py     = XW'(r_pos_y);
    assign sum_x  = px + dx;
    assign sum_y  = py + dx;
    assign cnt_e  = (dx < XW'(GRID) - px) ? dx : XW'(GRID) - px;
    assign cnt_w  = (dx < px + XW'(1)) ? dx : px + XW'(1);
    assign newx_e = (sum_x > XW'(GRID - 1)) ? CW'(GRID - 1) : CW'(sum_x);
    assign newx_w = (px >= dx) ? CW'(px - dx) : '0;
    assign newy_s = (sum_y > XW'(GRID - 1)) ? CW'(GRID - 1) : CW'(sum_y);
    assign newy_n = (py >= dx) ? CW'(py - dx) : '0;
    assign hi_s   = (sum_y < XW'(GRID)) ? sum_y : XW'(GRID);
    assign hi_n   = py + XW'(1);
    assign lo_n   = (hi_n >= dx) ? hi_n - dx : '0;
    assign mask_s = low_mask(hi_s) & ~low_mask(py);
    assign mask_n = low_mask(hi_n) & ~low_mask(lo_n);
    assign mask_col = GRID'(1) << r_pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos_x   <= CW'(RST_POS);
            r_pos_y   <= CW'(RST_POS);
            r_start_x <= 5'(START_RESET);
            r_start_y <= 5'(START_RESET);
            r_head    <= HEAD_EAST;
            r_pen     <= 1'b0;
            r_halt    <= 1'b0;
            r_vld     <= '0;
            r_wr_vld  <= 1'b0;
            r_pr_vld  <= 1'b0;
            r_fq_wp   <= 1'b0;
            r_fq_rp   <= 1'b0;
            r_fq_cnt  <= 2'd0;
        end else begin
            r_wr_vld <= (r_state == S_ROWS);
            r_pr_vld <= (r_state == S_PRINT) && credit_ok;
            if (r_wr_vld) begin
                r_vld[r_wr_addr] <= 1'b1;
            end
            if (r_pr_vld) begin
                r_fq_wp <= ~r_fq_wp;
            end
            if (pop) begin
                r_fq_rp <= ~r_fq_rp;
            end
            r_fq_cnt <= r_fq_cnt + 2'(r_pr_vld) - 2'(pop);

            case (r_state)
                S_IDLE: begin
                    if (in_acc && !r_halt) begin
                        case (t_req'(i_req_type))
                            REQ_PEN_UP:   r_pen  <= 1'b0;
                            REQ_PEN_DOWN: r_pen  <= 1'b1;
                            REQ_RIGHT:    r_head <= t_head'(r_head + 2'd1);
                            REQ_LEFT:     r_head <= t_head'(r_head + 2'd3);
                            REQ_END:      r_halt <= 1'b1;
                            REQ_PRINT: begin
                                r_state <= S_PRINT;
                                r_row   <= '0;
                                r_left  <= LW'(GRID);
                                r_dir   <= 1'b0;
                            end
                            REQ_MOVE: begin
                                r_row <= r_pos_x;
                                case (r_head)
                                    HEAD_EAST: begin
                                        r_pos_x <= newx_e;
                                        r_left  <= LW'(cnt_e);
                                        r_dir   <= 1'b0;
                                        r_mask  <= mask_col;
                                    end
                                    HEAD_WEST: begin
                                        r_pos_x <= newx_w;
                                        r_left  <= LW'(cnt_w);
                                        r_dir   <= 1'b1;
                                        r_mask  <= mask_col;
                                    end
                                    HEAD_SOUTH: begin
                                        r_pos_y <= newy_s;
                                        r_left  <= LW'(1);
                                        r_dir   <= 1'b0;
                                        r_mask  <= mask_s;
                                    end
                                    default: begin
                                        r_pos_y <= newy_n;
                                        r_left  <= LW'(1);
                                        r_dir   <= 1'b0;
                                        r_mask  <= mask_n;
                                    end
                                endcase
                                if (r_pen && (i_distance != 5'd0)) begin
                                    r_state <= S_ROWS;
                                end
                            end
                            default: ;
                        endcase
                    end else if (cfg_wr) begin
                        if (paddr[2] == REG_START_X) begin
                            r_start_x <= pwdata[4:0];
                            r_pos_x   <= clamp_start(pwdata[4:0]);
                        end else begin
                            r_start_y <= pwdata[4:0];
                            r_pos_y   <= clamp_start(pwdata[4:0]);
                        end
                    end
                end
                S_ROWS, S_PRINT: begin
                    if (rd_en) begin
                        r_row  <= r_dir ? r_row - CW'(1) : r_row + CW'(1);
                        r_left <= r_left - LW'(1);
                        if (r_left == LW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // grid memory, queue payload and read tags
    always_ff @(posedge i_clk) begin
        if (r_wr_vld) begin
            r_mem[r_wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
            r_vld_q <= r_vld[rd_addr];
        end
        r_wr_addr <= r_row;
        r_wr_mask <= r_mask;
        r_pr_idx  <= r_row;
        r_pr_last <= (r_left == LW'(1));
        if (r_pr_vld) begin
            r_fq_idx[r_fq_wp]  <= 5'(r_pr_idx);
            r_fq_bits[r_fq_wp] <= 32'(row_data);
            r_fq_last[r_fq_wp] <= r_pr_last;
        end
    end

    `TPP_ASSERT(a_fq_no_overflow, i_clk, i_rst_n, (3'(r_fq_cnt) + 3'(r_pr_vld)) <= 3'd2)
    `TPP_ASSERT(a_one_read_kind, i_clk, i_rst_n, !(r_wr_vld && r_pr_vld))
    `TPP_ASSERT_IMP(a_no_rmw_overlap, i_clk, i_rst_n, r_wr_vld && rd_en, rd_addr != r_wr_addr)
    `TPP_ASSERT_IMP(a_last_row_idx, i_clk, i_rst_n, o_out_valid && o_last_row, o_row_index == 5'(GRID - 1))

endmodule

`default_nettype wire

// File: verif/tpp_print_checker.sv
// Checker for turtle_pen_plotter_grid_unit: follows register writes and accepted
// commands, checks register reads, and predicts and compares every printed row word.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_print_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [2:0]                 i_req_type,
    input  logic [4:0]                 i_distance,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [4:0]                 i_row_index,
    input  logic [31:0]                i_row_bits,
    input  logic                       i_last_row,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic [31:0]                prdata,
    input  logic                       pready,
    output int                         o_mismatches,
    output int                         o_rows_owed
);

    localparam int GRID = 32;

    typedef struct packed {
        logic [4:0]  index;
        logic [31:0] bits;
        logic        last;
    } t_row_word;

    logic [31:0]     grid_q [GRID];
    logic [4:0]      start_x_q;
    logic [4:0]      start_y_q;
    int unsigned     pos_x;
    int unsigned     pos_y;
    tpp_pkg::t_head  heading_q;
    logic            pen_q;
    logic            halted_q;
    t_row_word       rows_due_q [$];
    int              mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
    endtask

    function automatic int unsigned clamp_coord(input int unsigned v);
        return (v > GRID - 1) ? GRID - 1 : v;
    endfunction

    task automatic mark_cell(input int unsigned row, input int unsigned col);
        if (row < GRID && col < GRID) begin
            grid_q[row][col] = 1'b1;
        end
    endtask

    task automatic plot_command(input logic [2:0] req, input int unsigned span);
        int unsigned k;
        logic [1:0]  turned;
        t_row_word   w;
        if (halted_q) return;
        case (req)
            tpp_pkg::REQ_PEN_UP: pen_q = 1'b0;
            tpp_pkg::REQ_PEN_DOWN: pen_q = 1'b1;
            tpp_pkg::REQ_RIGHT: begin
                turned = heading_q + 2'd1;
                heading_q = tpp_pkg::t_head'(turned);
            end
            tpp_pkg::REQ_LEFT: begin
                turned = heading_q + 2'd3;
                heading_q = tpp_pkg::t_head'(turned);
            end
            tpp_pkg::REQ_MOVE: begin
                case (heading_q)
                    tpp_pkg::HEAD_EAST: begin
                        if (pen_q) for (k = 0; k < span; k++) mark_cell(pos_x + k, pos_y);
                        pos_x = clamp_coord(pos_x + span);
                    end
                    tpp_pkg::HEAD_SOUTH: begin
                        if (pen_q) for (k = 0; k < span; k++) mark_cell(pos_x, pos_y + k);
                        pos_y = clamp_coord(pos_y + span);
                    end
                    tpp_pkg::HEAD_WEST: begin
                        if (pen_q) begin
                            for (k = 0; k < span && k <= pos_x; k++) mark_cell(pos_x - k, pos_y);
                        end
                        pos_x = (pos_x >= span) ? pos_x - span : 0;
                    end
                    default: begin
                        if (pen_q) begin
                            for (k = 0; k < span && k <= pos_y; k++) mark_cell(pos_x, pos_y - k);
                        end
                        pos_y = (pos_y >= span) ? pos_y - span : 0;
                    end
                endcase
            end
            tpp_pkg::REQ_PRINT: begin
                for (k = 0; k < GRID; k++) begin
                    w.index = k[4:0];
                    w.bits  = grid_q[k];
                    w.last  = (k == GRID - 1);
                    rows_due_q.push_back(w);
                end
            end
            tpp_pkg::REQ_END: halted_q = 1'b1;
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : check_p
        t_row_word  want;
        logic [4:0] reg_val;
        if (!i_rst_n) begin
            foreach (grid_q[r]) grid_q[r] = '0;
            start_x_q = 5'(tpp_pkg::START_RESET);
            start_y_q = 5'(tpp_pkg::START_RESET);
            pos_x     = clamp_coord(32'(start_x_q));
            pos_y     = clamp_coord(32'(start_y_q));
            heading_q = tpp_pkg::HEAD_EAST;
            pen_q     = 1'b0;
            halted_q  = 1'b0;
            rows_due_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[tpp_pkg::ADDR_W-1:2] == tpp_pkg::REG_START_X) begin
                        start_x_q = pwdata[4:0];
                        pos_x     = clamp_coord(32'(start_x_q));
                    end else begin
                        start_y_q = pwdata[4:0];
                        pos_y     = clamp_coord(32'(start_y_q));
                    end
                end else begin
                    reg_val = (paddr[tpp_pkg::ADDR_W-1:2] == tpp_pkg::REG_START_X) ?
                              start_x_q : start_y_q;
                    if (prdata !== {27'd0, reg_val}) begin
                        report_mismatch("register read", prdata, {27'd0, reg_val});
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (rows_due_q.size() == 0) begin
                    report_mismatch("row word with none pending", i_row_bits, 32'd0);
                end else begin
                    want = rows_due_q.pop_front();
                    if (i_row_index !== want.index) begin
                        report_mismatch("row_index", 32'(i_row_index), 32'(want.index));
                    end
                    if (i_row_bits !== want.bits) begin
                        report_mismatch("row_bits", i_row_bits, want.bits);
                    end
                    if (i_last_row !== want.last) begin
                        report_mismatch("last_row", 32'(i_last_row), 32'(want.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready) plot_command(i_req_type, 32'(i_distance));
        end
        o_rows_owed <= rows_due_q.size();
    end

endmodule

// File: verif/turtle_pen_plotter_grid_unit_tb.sv
// Testbench top for turtle_pen_plotter_grid_unit: clock, reset, command and
// register stimulus, output back-pressure, watchdog and verdict.
// Depends on tpp_pkg, tpp_print_checker and the plotter RTL.
`timescale 1ns / 1ps

module turtle_pen_plotter_grid_unit_tb;

    localparam logic [2:0] REQ_UNUSED  = 3'd7;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 46;
    localparam logic [tpp_pkg::ADDR_W-1:0] ADDR_START_X = {tpp_pkg::REG_START_X, 2'b00};
    localparam logic [tpp_pkg::ADDR_W-1:0] ADDR_START_Y = {tpp_pkg::REG_START_Y, 2'b00};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type  = tpp_pkg::REQ_PEN_UP;
    logic [4:0]  i_distance  = 5'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [4:0]  o_row_index;
    logic [31:0] o_row_bits;
    logic        o_last_row;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [tpp_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata      = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   rows_owed;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    logic hold_seen      = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    always #4 i_clk = ~i_clk;

    turtle_pen_plotter_grid_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_distance  (i_distance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row_index (o_row_index),
        .o_row_bits  (o_row_bits),
        .o_last_row  (o_last_row),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tpp_print_checker plot_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_distance   (i_distance),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_row_index  (o_row_index),
        .i_row_bits   (o_row_bits),
        .i_last_row   (o_last_row),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_rows_owed  (rows_owed)
    );

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("turtle_pen_plotter_grid_unit verification failed");
            $finish;
        end
    end

    // Leaves valid high on return; the caller sends again or idles the input.
    task automatic send_cmd(input logic [2:0] req, input logic [4:0] span);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_distance <= span;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_random_cmd();
        int         pick;
        logic [2:0] req;
        logic [4:0] span;
        pick = int'($urandom_range(99));
        span = 5'($urandom_range(31));
        if ($urandom_range(1) == 0) span = 5'($urandom_range(8));
        if (pick < 42)      req = tpp_pkg::REQ_MOVE;
        else if (pick < 56) req = tpp_pkg::REQ_PEN_DOWN;
        else if (pick < 64) req = tpp_pkg::REQ_PEN_UP;
        else if (pick < 76) req = tpp_pkg::REQ_RIGHT;
        else if (pick < 88) req = tpp_pkg::REQ_LEFT;
        else if (pick < 96) req = tpp_pkg::REQ_PRINT;
        else                req = REQ_UNUSED;
        send_cmd(req, span);
    endtask

    task automatic wait_idle();
        int settled;
        settled = 0;
        i_in_valid <= 1'b0;
        while (settled < DRAIN_CYCLES) begin
            @(posedge i_clk);
            settled = (rows_owed == 0) ? settled + 1 : 0;
        end
    endtask

    task automatic reg_write(input logic [tpp_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input logic [tpp_pkg::ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic [31:0] sx,
                             input logic [31:0] sy, input bit squeeze);
        wait_idle();
        reg_write(ADDR_START_X, sx);
        reg_write(ADDR_START_Y, sy);
        reg_read(ADDR_START_X);
        reg_read(ADDR_START_Y);
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (squeeze && n == PHASE_ITEMS / 2) begin
                // output held off while prints keep coming: input must stall
                hold_req <= ~hold_req;
                send_cmd(tpp_pkg::REQ_PRINT, 5'd0);
                send_cmd(tpp_pkg::REQ_PEN_DOWN, 5'd31);
                send_cmd(tpp_pkg::REQ_MOVE, 5'd31);
                send_cmd(tpp_pkg::REQ_PRINT, 5'd0);
                send_cmd(tpp_pkg::REQ_RIGHT, 5'd0);
                send_cmd(tpp_pkg::REQ_MOVE, 5'd12);
                send_cmd(tpp_pkg::REQ_PRINT, 5'd31);
            end
            send_random_cmd();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reg_read(ADDR_START_X);
        reg_read(ADDR_START_Y);

        // from the reset start position
        send_cmd(tpp_pkg::REQ_PRINT, 5'd31);
        send_cmd(tpp_pkg::REQ_PEN_DOWN, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd3);

        // from the far corner: edge clipping, heading wrap, pen up
        wait_idle();
        reg_write(ADDR_START_X, 32'd31);
        reg_write(ADDR_START_Y, 32'd31);
        reg_read(ADDR_START_X);
        reg_read(ADDR_START_Y);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd31);
        send_cmd(tpp_pkg::REQ_RIGHT, 5'd31);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd5);
        send_cmd(tpp_pkg::REQ_RIGHT, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd31);
        send_cmd(tpp_pkg::REQ_RIGHT, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd31);
        send_cmd(tpp_pkg::REQ_RIGHT, 5'd0);
        send_cmd(tpp_pkg::REQ_LEFT, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd3);
        send_cmd(tpp_pkg::REQ_PEN_UP, 5'd31);
        send_cmd(tpp_pkg::REQ_LEFT, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd7);
        send_cmd(REQ_UNUSED, 5'd31);
        send_cmd(tpp_pkg::REQ_PRINT, 5'd0);

        run_phase(0, 0, $urandom() & 32'hFFFF_FFE0, 32'd0, 1'b1);
        run_phase(72, 0, 32'd31, 32'd0, 1'b0);
        run_phase(0, 72, $urandom_range(31), $urandom_range(31), 1'b0);
        run_phase(7, 7, 32'd0, $urandom() | 32'h1F, 1'b0);

        // halt, then commands that must be dropped
        send_cmd(tpp_pkg::REQ_PRINT, 5'd0);
        send_cmd(tpp_pkg::REQ_END, 5'd0);
        send_cmd(tpp_pkg::REQ_PRINT, 5'd31);
        send_cmd(tpp_pkg::REQ_PEN_DOWN, 5'd0);
        send_cmd(tpp_pkg::REQ_MOVE, 5'd9);
        send_cmd(REQ_UNUSED, 5'd0);
        wait_idle();

        if (mismatches == 0 && rows_owed == 0) begin
            $display("turtle_pen_plotter_grid_unit verification clean");
        end else begin
            $display("turtle_pen_plotter_grid_unit verification failed");
        end
        $finish;
    end

endmodule

// File: turtle_pen_plotter_grid_unit.f
+incdir+rtl/core
rtl/core/tpp_pkg.sv
rtl/core/turtle_pen_plotter_grid_unit.sv
verif/tpp_print_checker.sv
verif/turtle_pen_plotter_grid_unit_tb.sv
